// ===== hdl/pfc_pkg.sv =====
// Package for the packet frame checker: shared constants, status codes and the
// work item type that runs from the front end through the queue to the back end.
// No dependencies.
`timescale 1ns / 1ps

package pfc_pkg;

	localparam int HDR_BYTES = 16;
	localparam int QDEPTH = 2;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [16:0] POS_MAX = 17'h1FFFF;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FORMAT = 2'd1,
		ST_CRC    = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] flags;
		logic [15:0] length;
		logic [31:0] rcrc;
	} header_t;

	// One classified byte as handed from the front end to the CRC back end.
	typedef struct packed {
		logic [7:0] data;
		logic       crc_en;
		logic       crc_zero;
		logic       pass;
		logic       mark_final;
		logic       last;
		logic       short_hdr;
		logic       len_ok;
		header_t    hdr;
	} work_t;

endpackage

// ===== hdl/pfc_ifs.sv =====
// Channel interfaces of the packet frame checker: received bytes, results and
// the capacity register write channel. No dependencies.
`timescale 1ns / 1ps

interface byte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_datagram;

	modport source (output valid, rx_byte, end_of_datagram, input ready);
	modport sink (input valid, rx_byte, end_of_datagram, output ready);
endinterface

interface result_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        frame_done;
	logic [1:0]  status;
	logic [31:0] seq_number;
	logic [31:0] ack_number;
	logic [15:0] flag_bits;
	logic [15:0] data_length;
	logic [31:0] received_crc;

	modport source (output valid, payload_valid, payload_byte, frame_done, status,
		seq_number, ack_number, flag_bits, data_length, received_crc, input ready);
	modport sink (input valid, payload_valid, payload_byte, frame_done, status,
		seq_number, ack_number, flag_bits, data_length, received_crc, output ready);
endinterface

interface cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hdl/packet_frame_checker.sv =====
// Packet frame checker top level: front end, queue and CRC back end.
// Depends on pfc_pkg, pfc_ifs, pfc_front, pfc_queue and pfc_back.
//
// The block takes one datagram byte per cycle while rx is ready and checks a
// 16-byte big-endian header (sequence, acknowledgment, flags, length, CRC) plus
// the declared payload against a reflected CRC-32, with the CRC field counted
// as zero bytes. Payload bytes are passed on tx as they arrive when the declared
// length is within MAX_DATA and the capacity register; the result for the last
// byte carries frame_done, the header fields and the status (ok, format error,
// CRC mismatch). Passed bytes must be dropped by the user when the status is
// not ok. Sustained rate is one byte per cycle unless tx stalls, set by the CRC
// byte update in the back end; a result passes the queue and the result
// register before tx shows it. A two-entry queue separates byte classification
// from the CRC unit and the result register, so rx takes up to two more bytes
// while a result waits on tx before it stalls. The capacity register resets to
// 65535; the user writes it only between datagrams, not enforced by the block.
`timescale 1ns / 1ps

module packet_frame_checker import pfc_pkg::*; #(
	parameter int MAX_DATA = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	byte_in_if.sink   rx,
	result_if.source  tx,
	cfg_if.sink       cfg
);

	logic  push, pop, q_full, q_empty;
	work_t push_data, pop_data;

	pfc_front #(
		.MAX_DATA (MAX_DATA)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	pfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	pfc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.pop_data (pop_data),
		.pop      (pop),
		.tx       (tx)
	);

endmodule

// ===== hdl/pfc_front.sv =====
// Front end of the packet frame checker: byte position, header capture, length
// check and classification of each byte. Depends on pfc_pkg and pfc_ifs.
`timescale 1ns / 1ps

module pfc_front import pfc_pkg::*; #(
	parameter int MAX_DATA = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	byte_in_if.sink    rx,
	cfg_if.sink        cfg,
	input  logic       q_full,
	output logic       push,
	output work_t      push_data
);

	logic [16:0] pos_q;
	logic [63:0] hdr0_q, hdr1_q;
	logic [63:0] hdr0_n, hdr1_n;
	logic        len_ok_q, len_ok_n;
	logic [15:0] cap_q;
	logic [15:0] dlen, dlen_at11;
	logic        is_hdr, in_pay, acc;

	assign rx.ready  = !q_full;
	assign acc       = rx.valid && rx.ready;
	assign push      = acc;
	assign cfg.ready = 1'b1;

	assign is_hdr    = pos_q < 17'(HDR_BYTES);
	assign dlen      = hdr1_q[47:32];
	assign dlen_at11 = {hdr1_q[47:40], rx.rx_byte};

	always_comb begin
		hdr0_n = hdr0_q;
		hdr1_n = hdr1_q;
		if (is_hdr) begin
			// Header bytes land at their big-endian place in one of two words.
			if (!pos_q[3]) begin
				hdr0_n[{~pos_q[2:0], 3'b000} +: 8] = rx.rx_byte;
			end else begin
				hdr1_n[{~pos_q[2:0], 3'b000} +: 8] = rx.rx_byte;
			end
		end
		len_ok_n = len_ok_q;
		if (pos_q == 17'd11) begin
			len_ok_n = (dlen_at11 <= 16'(MAX_DATA)) && (dlen_at11 <= cap_q);
		end
	end

	assign in_pay = !is_hdr && (pos_q < 17'(HDR_BYTES) + {1'b0, dlen});

	always_comb begin
		push_data.data       = rx.rx_byte;
		push_data.crc_en     = is_hdr || in_pay;
		// The CRC field itself enters the checksum as zero bytes.
		push_data.crc_zero   = is_hdr && (pos_q[3:2] == 2'b11);
		push_data.pass       = in_pay && len_ok_q;
		push_data.mark_final = pos_q == 17'(HDR_BYTES - 1) + {1'b0, dlen};
		push_data.last       = rx.end_of_datagram;
		push_data.short_hdr  = pos_q < 17'(HDR_BYTES - 1);
		push_data.len_ok     = len_ok_n;
		push_data.hdr.seq    = hdr0_n[63:32];
		push_data.hdr.ack    = hdr0_n[31:0];
		push_data.hdr.flags  = hdr1_n[63:48];
		push_data.hdr.length = hdr1_n[47:32];
		push_data.hdr.rcrc   = hdr1_n[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hdr0_q   <= '0;
			hdr1_q   <= '0;
			len_ok_q <= 1'b0;
			cap_q    <= 16'hFFFF;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			if (acc) begin
				if (rx.end_of_datagram) begin
					pos_q    <= '0;
					hdr0_q   <= '0;
					hdr1_q   <= '0;
					len_ok_q <= 1'b0;
				end else begin
					if (pos_q != POS_MAX) begin
						pos_q <= pos_q + 17'd1;
					end
					hdr0_q   <= hdr0_n;
					hdr1_q   <= hdr1_n;
					len_ok_q <= len_ok_n;
				end
			end
		end
	end

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && rx.end_of_datagram) |=> (pos_q == '0 && !len_ok_q))
		else $error("front end did not restart after the last byte");

endmodule

// ===== hdl/pfc_queue.sv =====
// Two-entry queue between the front end and the CRC back end of the packet
// frame checker. Depends on pfc_pkg.
`timescale 1ns / 1ps

module pfc_queue import pfc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_data,
	output logic  full,
	input  logic  pop,
	output work_t pop_data,
	output logic  empty
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	work_t         entry_q [QDEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full     = count_q == CW'(QDEPTH);
	assign empty    = count_q == '0;
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("queue holds more items than it has entries");

endmodule

// ===== hdl/pfc_back.sv =====
// Back end of the packet frame checker: CRC-32 update, final status and the
// result register. Depends on pfc_pkg and pfc_ifs.
`timescale 1ns / 1ps

module pfc_back import pfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  work_t     pop_data,
	output logic      pop,
	result_if.source  tx
);

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

	logic [31:0] crc_q, final_q;
	logic        complete_q;
	logic [31:0] crc_n, final_n;
	logic        complete_n;
	status_t     st_n;
	logic        emit;
	work_t       w;

	logic        out_valid_q;
	logic        pv_q;
	logic [7:0]  pbyte_q;
	logic        done_q;
	status_t     st_q;
	header_t     hdr_q;

	assign w    = pop_data;
	assign pop  = !empty && (!out_valid_q || tx.ready);
	assign emit = w.pass || w.last;

	always_comb begin
		crc_n      = w.crc_en ? crc_byte(crc_q, w.crc_zero ? 8'h00 : w.data) : crc_q;
		final_n    = w.mark_final ? ~crc_n : final_q;
		complete_n = complete_q || w.mark_final;
		if (w.short_hdr || !w.len_ok || !complete_n) begin
			st_n = ST_FORMAT;
		end else if (final_n != w.hdr.rcrc) begin
			st_n = ST_CRC;
		end else begin
			st_n = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_INIT;
			final_q     <= '0;
			complete_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (w.last) begin
					crc_q      <= CRC_INIT;
					final_q    <= '0;
					complete_q <= 1'b0;
				end else begin
					crc_q      <= crc_n;
					final_q    <= final_n;
					complete_q <= complete_n;
				end
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Fields that carry no meaning in a result are forced to zero.
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			pv_q    <= w.pass;
			pbyte_q <= w.pass ? w.data : 8'h00;
			done_q  <= w.last;
			st_q    <= w.last ? st_n : ST_OK;
			hdr_q   <= w.last ? w.hdr : '0;
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.payload_valid = pv_q;
	assign tx.payload_byte  = pbyte_q;
	assign tx.frame_done    = done_q;
	assign tx.status        = st_q;
	assign tx.seq_number    = hdr_q.seq;
	assign tx.ack_number    = hdr_q.ack;
	assign tx.flag_bits     = hdr_q.flags;
	assign tx.data_length   = hdr_q.length;
	assign tx.received_crc  = hdr_q.rcrc;

	a_result_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (pv_q || done_q))
		else $error("result shown with neither payload nor frame end");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !done_q) |-> (st_q == ST_OK && hdr_q == '0))
		else $error("status or header fields set on a payload-only result");

endmodule

// ===== tb/frame_result_monitor.sv =====
// Result monitor for the packet frame checker: follows every accepted byte and capacity
// write, predicts the output items of the block and compares them in order of arrival.
// Depends on pfc_pkg and the channel interfaces of pfc_ifs.
`timescale 1ns / 1ps

module frame_result_monitor import pfc_pkg::*; #(
	parameter int MAX_DATA = 1024
) (
	input  logic clk,
	input  logic arst_n,
	byte_in_if   rx,
	result_if    tx,
	cfg_if       cfg,
	output int   mismatches,
	output int   outstanding
);

	localparam logic [31:0] POLY = 32'hEDB88320;
	localparam logic [16:0] POS_LIMIT = 17'h1FFFF;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        frame_done;
		status_t     status;
		logic [31:0] seq_number;
		logic [31:0] ack_number;
		logic [15:0] flag_bits;
		logic [15:0] data_length;
		logic [31:0] received_crc;
	} frame_result_t;

	logic [16:0]   position;
	logic [31:0]   crc_acc;
	logic [31:0]   crc_sum;
	logic          crc_covered;
	logic          length_fits;
	logic [63:0]   header_word [2];
	logic [15:0]   capacity;
	frame_result_t pending_results [$];
	frame_result_t observed;
	frame_result_t predicted;
	int            failures;

	function automatic logic [31:0] crc_update(logic [31:0] crc, logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ POLY) : (c >> 1);
		return c;
	endfunction

	function automatic string describe(frame_result_t r);
		return $sformatf("pv=%0d byte=%02h done=%0d status=%0d seq=%08h ack=%08h flags=%04h len=%04h crc=%08h",
			r.payload_valid, r.payload_byte, r.frame_done, r.status, r.seq_number,
			r.ack_number, r.flag_bits, r.data_length, r.received_crc);
	endfunction

	task automatic clear_frame();
		position = '0;
		crc_acc = '1;
		crc_sum = '0;
		crc_covered = 1'b0;
		length_fits = 1'b0;
		header_word[0] = '0;
		header_word[1] = '0;
	endtask

	task automatic deframe_byte(input logic [7:0] data, input logic is_last);
		frame_result_t r;
		logic [16:0] p;
		logic [15:0] dlen;
		r = '0;
		p = position;
		if (p < 17'd16) begin
			header_word[p[3]][8 * (7 - p[2:0]) +: 8] = data;
			// The four CRC bytes of the header enter the checksum as zeros.
			crc_acc = crc_update(crc_acc, (p >= 17'd12) ? 8'h00 : data);
			if (p == 17'd11)
				length_fits = (header_word[1][47:32] <= MAX_DATA)
					&& (header_word[1][47:32] <= capacity);
		end else begin
			dlen = header_word[1][47:32];
			if (int'(p) < 16 + int'(dlen)) begin
				crc_acc = crc_update(crc_acc, data);
				if (length_fits) begin
					r.payload_valid = 1'b1;
					r.payload_byte = data;
				end
			end
		end
		dlen = header_word[1][47:32];
		if (int'(p) == 15 + int'(dlen)) begin
			crc_sum = ~crc_acc;
			crc_covered = 1'b1;
		end
		if (position != POS_LIMIT)
			position = position + 17'd1;
		if (is_last) begin
			r.frame_done = 1'b1;
			r.seq_number = header_word[0][63:32];
			r.ack_number = header_word[0][31:0];
			r.flag_bits = header_word[1][63:48];
			r.data_length = header_word[1][47:32];
			r.received_crc = header_word[1][31:0];
			if (p < 17'd15 || !length_fits || !crc_covered)
				r.status = ST_FORMAT;
			else if (crc_sum != header_word[1][31:0])
				r.status = ST_CRC;
			else
				r.status = ST_OK;
			clear_frame();
		end
		if (r.payload_valid || r.frame_done)
			pending_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			capacity = 16'hFFFF;
			pending_results.delete();
			failures = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				capacity = cfg.data;
			if (tx.valid && tx.ready) begin
				observed = {tx.payload_valid, tx.payload_byte, tx.frame_done, tx.status,
					tx.seq_number, tx.ack_number, tx.flag_bits, tx.data_length,
					tx.received_crc};
				if (pending_results.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("unexpected output item: %s", describe(observed));
				end else begin
					predicted = pending_results.pop_front();
					if (observed !== predicted) begin
						failures++;
						if (failures <= REPORT_LIMIT) begin
							$display("mismatch, expected %s", describe(predicted));
							$display("          actual   %s", describe(observed));
						end
					end
				end
			end
			if (rx.valid && rx.ready)
				deframe_byte(rx.rx_byte, rx.end_of_datagram);
			mismatches <= failures;
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Top of the packet frame checker testbench: clock, reset, datagram stimulus, capacity
// writes, random back-pressure and the verdict. Depends on pfc_pkg, pfc_ifs, the block
// itself and frame_result_monitor, which does the prediction and comparison.
`timescale 1ns / 1ps

module tb;
	import pfc_pkg::*;

	localparam int MAX_DATA = 1024;
	localparam int RUN_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int PHASE_BYTES = 180;

	logic        clk;
	logic        arst_n;
	int          mismatches;
	int          outstanding;
	int unsigned cycle_count;
	int          bytes_sent;
	bit          steady;
	bit          hold_off_req;

	byte_in_if rx_ch();
	result_if  tx_ch();
	cfg_if     cfg_ch();

	packet_frame_checker #(.MAX_DATA(MAX_DATA)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch),
		.cfg    (cfg_ch)
	);

	frame_result_monitor #(.MAX_DATA(MAX_DATA)) monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx_ch),
		.tx          (tx_ch),
		.cfg         (cfg_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] crc_next(logic [31:0] crc, logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		return c;
	endfunction

	// Header words lean towards all zeros and all ones so that the extremes turn up often.
	function automatic logic [31:0] skewed_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	function automatic header_t random_header();
		header_t h;
		h.seq = skewed_word();
		h.ack = skewed_word();
		h.flags = 16'(skewed_word());
		h.length = '0;
		h.rcrc = $urandom;
		return h;
	endfunction

	// The receiver ready pattern: short stalls mostly, now and then a long run without any.
	initial begin
		int n;
		tx_ch.ready = 1'b0;
		forever begin
			if (hold_off_req) begin
				tx_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			n = pick_gap();
			if (n > 0) begin
				tx_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			tx_ch.ready <= 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 6)) @(posedge clk);
		end
	end

	task automatic push_byte(input logic [7:0] data, input logic is_last);
		int g;
		g = steady ? 0 : pick_gap();
		if (g > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= data;
		rx_ch.end_of_datagram <= is_last;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
	endtask

	// Returns once every predicted item has arrived and the pipeline has had time to settle.
	task automatic wait_idle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Sends header, n_pay payload bytes and n_tail trailing bytes, or only the first cut
	// bytes when cut is positive. With fix_crc set the header carries the correct checksum.
	task automatic send_frame(input header_t hdr, input int n_pay, input int n_tail,
		input bit fix_crc, input int cut);
		logic [7:0] pay [$];
		logic [31:0] c;
		logic [7:0] b;
		int total;
		int covered;
		for (int i = 0; i < n_pay; i++)
			pay.push_back(8'($urandom));
		if (fix_crc) begin
			c = '1;
			for (int i = 0; i < 12; i++)
				c = crc_next(c, hdr[127 - 8 * i -: 8]);
			for (int i = 0; i < 4; i++)
				c = crc_next(c, 8'h00);
			covered = (n_pay < int'(hdr.length)) ? n_pay : int'(hdr.length);
			for (int i = 0; i < covered; i++)
				c = crc_next(c, pay[i]);
			hdr.rcrc = ~c;
		end
		total = (cut > 0) ? cut : 16 + n_pay + n_tail;
		for (int i = 0; i < total; i++) begin
			if (i < 16)
				b = hdr[127 - 8 * i -: 8];
			else if (i < 16 + n_pay)
				b = pay[i - 16];
			else
				b = 8'($urandom);
			push_byte(b, i == total - 1);
		end
	endtask

	// Mostly well-formed datagrams with random content; the rest are broken or plain noise.
	task automatic random_frame();
		header_t h;
		int kind;
		int len;
		kind = $urandom_range(0, 99);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
		steady = ($urandom_range(0, 4) == 0);
		h = random_header();
		h.length = 16'(len);
		if (kind < 75) begin
			send_frame(h, len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0,
				1'b1, 0);
		end else if (kind < 80) begin
			send_frame(h, len, 0, 1'b0, 0);
		end else if (kind < 86) begin
			send_frame(h, len, 0, 1'b1, $urandom_range(1, 16));
		end else if (kind < 92) begin
			h.length = 16'(len + 1);
			send_frame(h, $urandom_range(0, len), 0, 1'b1, 0);
		end else if (kind < 96) begin
			h.length = 16'($urandom_range(MAX_DATA + 1, 65535));
			send_frame(h, $urandom_range(0, 6), 0, 1'b1, 0);
		end else begin
			h.length = 16'($urandom);
			send_frame(h, 40, 0, 1'b0, $urandom_range(1, 40));
		end
	endtask

	initial begin
		header_t h;
		int phase_end;
		logic [15:0] caps [5];
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		rx_ch.end_of_datagram = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		write_capacity(16'hFFFF);

		h = random_header();
		h.seq = '1;
		h.ack = '0;
		h.flags = '1;
		send_frame(h, 0, 0, 1'b1, 0);
		h.seq = '0;
		h.ack = '1;
		h.flags = '0;
		h.length = 16'd4;
		send_frame(h, 4, 0, 1'b1, 0);
		h = random_header();
		h.length = 16'd4;
		send_frame(h, 4, 0, 1'b0, 0);
		// Datagrams that end inside the header.
		send_frame(h, 0, 0, 1'b1, 1);
		send_frame(h, 0, 0, 1'b1, 5);
		send_frame(h, 0, 0, 1'b1, 15);
		h.length = 16'd5;
		send_frame(h, 0, 0, 1'b1, 16);
		h.length = 16'd10;
		send_frame(h, 3, 0, 1'b1, 0);
		h.length = 16'd2;
		send_frame(h, 2, 5, 1'b1, 0);
		h.length = 16'(MAX_DATA + 1);
		send_frame(h, 3, 0, 1'b1, 0);
		h.length = 16'hFFFF;
		send_frame(h, 0, 0, 1'b1, 0);
		// A length right at the limit still lets its payload bytes through.
		h.length = 16'(MAX_DATA);
		send_frame(h, 3, 0, 1'b1, 0);
		write_capacity(16'd0);
		h.length = 16'd0;
		send_frame(h, 0, 0, 1'b1, 0);
		h.length = 16'd1;
		send_frame(h, 1, 0, 1'b1, 0);

		caps = '{16'($urandom), 16'd0, 16'($urandom_range(1, 12)), 16'(MAX_DATA), 16'hFFFF};
		foreach (caps[i]) begin
			write_capacity(caps[i]);
			if (i == 4) begin
				// The receiver holds off while the sender keeps offering bytes back to back.
				hold_off_req = 1'b1;
				steady = 1'b1;
				h = random_header();
				h.length = 16'd120;
				send_frame(h, 120, 0, 1'b1, 0);
			end
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end)
				random_frame();
		end
		wait_idle();

		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
